// File: design/sexp_tok_pkg.sv
// ---------------------------------------------------------------------------
// S-expression tokenizer package
// Shared event codes, character constants, result types and the character
// classification and escape-translation functions.
// ---------------------------------------------------------------------------
package sexp_tok_pkg;

   localparam int unsigned MaxDepthDefault = 255;
   localparam int CharW = 21;
   localparam int NestW = 8;

   typedef enum logic [3:0] {
      EV_ACHAR = 4'd0,
      EV_AEND  = 4'd1,
      EV_SCHAR = 4'd2,
      EV_SEND  = 4'd3,
      EV_OPEN  = 4'd4,
      EV_CLOSE = 4'd5,
      EV_EXTRA = 4'd6,
      EV_OVER  = 4'd7,
      EV_OK    = 4'd8,
      EV_BAD   = 4'd9
   } event_type;

   localparam logic [CharW-1:0] CH_QUOTE  = 21'h22;
   localparam logic [CharW-1:0] CH_APOS   = 21'h27;
   localparam logic [CharW-1:0] CH_LPAR   = 21'h28;
   localparam logic [CharW-1:0] CH_RPAR   = 21'h29;
   localparam logic [CharW-1:0] CH_BSLASH = 21'h5C;
   localparam logic [CharW-1:0] CH_A      = 21'h61;
   localparam logic [CharW-1:0] CH_B      = 21'h62;
   localparam logic [CharW-1:0] CH_F      = 21'h66;
   localparam logic [CharW-1:0] CH_N      = 21'h6E;
   localparam logic [CharW-1:0] CH_R      = 21'h72;
   localparam logic [CharW-1:0] CH_T      = 21'h74;
   localparam logic [CharW-1:0] CH_V      = 21'h76;
   localparam logic [CharW-1:0] CH_BEL    = 21'h07;
   localparam logic [CharW-1:0] CH_BS     = 21'h08;
   localparam logic [CharW-1:0] CH_TAB    = 21'h09;
   localparam logic [CharW-1:0] CH_LF     = 21'h0A;
   localparam logic [CharW-1:0] CH_VT     = 21'h0B;
   localparam logic [CharW-1:0] CH_FF     = 21'h0C;
   localparam logic [CharW-1:0] CH_CR     = 21'h0D;

   typedef struct packed {
      event_type        ev;
      logic [CharW-1:0] ch;
      logic [NestW-1:0] depth;
   } result_type;

   // up to two results caused by one input item
   typedef struct packed {
      logic [1:0] count;
      result_type r0;
      result_type r1;
   } pair_type;

   typedef struct packed {
      logic             known;
      logic [CharW-1:0] ch;
   } unesc_type;

   function automatic logic is_space(input logic [CharW-1:0] c);
      return c inside {[21'h09:21'h0D], [21'h1C:21'h20], [21'h2000:21'h200A],
                       21'h85, 21'hA0, 21'h1680, 21'h2028, 21'h2029,
                       21'h202F, 21'h205F, 21'h3000};
   endfunction

   function automatic unesc_type unescape(input logic [CharW-1:0] c);
      unesc_type u;
      u.known = 1'b1;
      u.ch    = c;
      case (c)
         CH_BSLASH, CH_APOS, CH_QUOTE: u.ch = c;
         CH_B:    u.ch = CH_BS;
         CH_F:    u.ch = CH_FF;
         CH_T:    u.ch = CH_TAB;
         CH_N:    u.ch = CH_LF;
         CH_R:    u.ch = CH_CR;
         CH_V:    u.ch = CH_VT;
         CH_A:    u.ch = CH_BEL;
         default: u.known = 1'b0;
      endcase
      return u;
   endfunction

endpackage

// File: design/sexp_tok_core.sv
// ---------------------------------------------------------------------------
// S-expression tokenizer core
// Parser state registers and the single-pass step logic that turns one
// character (or the end marker) into zero, one or two result events.
// ---------------------------------------------------------------------------
module sexp_tok_core #(
   parameter int unsigned MAX_DEPTH = sexp_tok_pkg::MaxDepthDefault
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step_en,
   input  logic [sexp_tok_pkg::CharW-1:0] code_point,
   input  logic                          end_marker,
   output sexp_tok_pkg::pair_type        pair
);

   localparam int DepthW = $clog2(MAX_DEPTH + 1);

   logic              esc_ff, esc_in;
   logic              atom_ff, atom_in;
   logic              str_ff, str_in;
   logic [DepthW-1:0] depth_ff, depth_in;
   logic              top_ff, top_in;
   logic              fail_ff, fail_in;

   logic                          pre_v, main_v, top_eff, space, delim;
   sexp_tok_pkg::event_type       pre_ev, main_ev;
   logic [sexp_tok_pkg::CharW-1:0] pre_ch, main_ch;
   logic [DepthW-1:0]             main_depth;
   sexp_tok_pkg::unesc_type       ue;
   sexp_tok_pkg::result_type      pre_r, main_r;

   always_comb begin
      esc_in  = esc_ff;
      atom_in = atom_ff;
      str_in  = str_ff;
      depth_in = depth_ff;
      top_in  = top_ff;
      fail_in = fail_ff;
      pre_v   = 1'b0;
      pre_ev  = sexp_tok_pkg::EV_AEND;
      pre_ch  = '0;
      main_v  = 1'b0;
      main_ev = sexp_tok_pkg::EV_OK;
      main_ch = '0;
      top_eff = top_ff;
      ue      = sexp_tok_pkg::unescape(code_point);
      space   = sexp_tok_pkg::is_space(code_point);
      delim   = (code_point == sexp_tok_pkg::CH_LPAR) || (code_point == sexp_tok_pkg::CH_RPAR) ||
                (code_point == sexp_tok_pkg::CH_QUOTE) || space;

      if (end_marker) begin
         if (atom_ff && !fail_ff) begin
            pre_v = 1'b1;
            if (depth_ff == '0) top_eff = 1'b1;
         end
         main_v  = 1'b1;
         main_ev = (fail_ff || depth_ff != '0 || !top_eff) ? sexp_tok_pkg::EV_BAD
                                                          : sexp_tok_pkg::EV_OK;
         esc_in   = 1'b0;
         atom_in  = 1'b0;
         str_in   = 1'b0;
         depth_in = '0;
         top_in   = 1'b0;
         fail_in  = 1'b0;
      end else if (!fail_ff) begin
         if (str_ff) begin
            if (esc_ff) begin
               esc_in  = 1'b0;
               main_v  = 1'b1;
               main_ev = sexp_tok_pkg::EV_SCHAR;
               main_ch = ue.ch;
               if (!ue.known || code_point == sexp_tok_pkg::CH_QUOTE) begin
                  pre_v  = 1'b1;
                  pre_ev = sexp_tok_pkg::EV_SCHAR;
                  pre_ch = sexp_tok_pkg::CH_BSLASH;
               end
            end else if (code_point == sexp_tok_pkg::CH_BSLASH) begin
               esc_in = 1'b1;
            end else if (code_point == sexp_tok_pkg::CH_QUOTE) begin
               str_in  = 1'b0;
               main_v  = 1'b1;
               main_ev = sexp_tok_pkg::EV_SEND;
               main_ch = sexp_tok_pkg::CH_QUOTE;
               if (depth_ff == '0) top_in = 1'b1;
            end else begin
               main_v  = 1'b1;
               main_ev = sexp_tok_pkg::EV_SCHAR;
               main_ch = code_point;
            end
         end else if (atom_ff && !delim) begin
            main_v  = 1'b1;
            main_ev = sexp_tok_pkg::EV_ACHAR;
            main_ch = code_point;
         end else begin
            // a delimiter closes a running atom, then is handled as usual
            if (atom_ff) begin
               atom_in = 1'b0;
               pre_v   = 1'b1;
               if (depth_ff == '0) top_in = 1'b1;
            end
            if (esc_ff) begin
               esc_in  = 1'b0;
               atom_in = 1'b1;
               main_v  = 1'b1;
               main_ev = sexp_tok_pkg::EV_ACHAR;
               main_ch = ue.ch;
               if (!ue.known) begin
                  pre_v  = 1'b1;
                  pre_ev = sexp_tok_pkg::EV_ACHAR;
                  pre_ch = sexp_tok_pkg::CH_BSLASH;
               end
            end else if (code_point == sexp_tok_pkg::CH_BSLASH) begin
               esc_in = 1'b1;
            end else if (space) begin
               esc_in = 1'b0;
            end else if (code_point == sexp_tok_pkg::CH_LPAR) begin
               main_v = 1'b1;
               if (depth_ff >= DepthW'(MAX_DEPTH)) begin
                  fail_in = 1'b1;
                  main_ev = sexp_tok_pkg::EV_OVER;
               end else begin
                  depth_in = depth_ff + DepthW'(1);
                  main_ev  = sexp_tok_pkg::EV_OPEN;
               end
            end else if (code_point == sexp_tok_pkg::CH_RPAR) begin
               main_v = 1'b1;
               if (depth_ff == '0) begin
                  fail_in = 1'b1;
                  main_ev = sexp_tok_pkg::EV_EXTRA;
               end else begin
                  depth_in = depth_ff - DepthW'(1);
                  main_ev  = sexp_tok_pkg::EV_CLOSE;
                  if (depth_ff == DepthW'(1)) top_in = 1'b1;
               end
            end else if (code_point == sexp_tok_pkg::CH_QUOTE) begin
               str_in  = 1'b1;
               main_v  = 1'b1;
               main_ev = sexp_tok_pkg::EV_SCHAR;
               main_ch = sexp_tok_pkg::CH_QUOTE;
            end else begin
               atom_in = 1'b1;
               main_v  = 1'b1;
               main_ev = sexp_tok_pkg::EV_ACHAR;
               main_ch = code_point;
            end
         end
      end

      main_depth = end_marker ? depth_ff : depth_in;
   end

   always_comb begin
      pre_r.ev     = pre_ev;
      pre_r.ch     = pre_ch;
      pre_r.depth  = sexp_tok_pkg::NestW'(depth_ff);
      main_r.ev    = main_ev;
      main_r.ch    = main_ch;
      main_r.depth = sexp_tok_pkg::NestW'(main_depth);
      pair.count   = {1'b0, pre_v} + {1'b0, main_v};
      pair.r0      = pre_v ? pre_r : main_r;
      pair.r1      = main_r;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         esc_ff   <= 1'b0;
         atom_ff  <= 1'b0;
         str_ff   <= 1'b0;
         depth_ff <= '0;
         top_ff   <= 1'b0;
         fail_ff  <= 1'b0;
      end else if (step_en) begin
         esc_ff   <= esc_in;
         atom_ff  <= atom_in;
         str_ff   <= str_in;
         depth_ff <= depth_in;
         top_ff   <= top_in;
         fail_ff  <= fail_in;
      end
   end

   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      depth_ff <= DepthW'(MAX_DEPTH))
      else $error("list depth above limit");

   a_atom_str_excl: assert property (@(posedge clock) disable iff (reset)
      !(atom_ff && str_ff))
      else $error("inside atom and string at once");

   a_no_esc_in_atom: assert property (@(posedge clock) disable iff (reset)
      !(atom_ff && esc_ff))
      else $error("escape pending inside atom");

endmodule

// File: design/sexp_tok_outq.sv
// ---------------------------------------------------------------------------
// S-expression tokenizer result buffer
// Holds the results of one item and hands them out one beat at a time.
// ---------------------------------------------------------------------------
module sexp_tok_outq (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           load_en,
   input  sexp_tok_pkg::pair_type         load_pair,
   output logic                           ready,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [3:0]                     rsp_event_res,
   output logic [sexp_tok_pkg::CharW-1:0] rsp_char_value,
   output logic [sexp_tok_pkg::NestW-1:0] rsp_nest_depth,
   output logic                           rsp_last_of_item
);

   logic                     valid_ff, valid_in;
   logic                     idx_ff, idx_in;
   sexp_tok_pkg::pair_type   pair_ff, pair_in;
   sexp_tok_pkg::result_type cur;
   logic                     last, beat, done;

   always_comb begin
      cur      = idx_ff ? pair_ff.r1 : pair_ff.r0;
      last     = (pair_ff.count != 2'd2) || idx_ff;
      beat     = valid_ff && !rsp_stall;
      done     = beat && last;
      ready    = !valid_ff || done;
      valid_in = valid_ff;
      idx_in   = idx_ff;
      pair_in  = pair_ff;
      if (load_en) begin
         valid_in = 1'b1;
         idx_in   = 1'b0;
         pair_in  = load_pair;
      end else if (done) begin
         valid_in = 1'b0;
      end else if (beat) begin
         idx_in = 1'b1;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_event_res    = cur.ev;
   assign rsp_char_value   = cur.ch;
   assign rsp_nest_depth   = cur.depth;
   assign rsp_last_of_item = last;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
      pair_ff <= pair_in;
   end

   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> pair_ff.count != 2'd0)
      else $error("buffer valid with no results");

   a_second_needs_two: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && idx_ff) |-> pair_ff.count == 2'd2)
      else $error("second beat of a single-result item");

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      load_en |-> ready)
      else $error("load into a busy buffer");

endmodule

// File: design/sexp_tokenizer_unit.sv
// ---------------------------------------------------------------------------
// S-expression tokenizer unit
// Streams one code point per beat and emits token events with depth.
// ---------------------------------------------------------------------------
// Each request beat carries one Unicode code point, or the end marker, and
// yields zero, one or two response beats: atom characters, atom end, string
// characters (quotes kept, escapes translated), string end, list open and
// close, and the error and status events. The final response of an item has
// rsp_last_of_item set; items that only change state (whitespace, a
// backslash that opens an escape, any character after an error) give none.
// The unit takes one item per clock while the result buffer can take its
// results; a receiver stall, or a two-event item that holds the result
// buffer until both beats are sent, stalls the input. The two-entry result
// buffer behind the step logic holds the results of one item. A request
// passes the input register and then the result buffer on its way to the
// first response beat. After the end marker the status event is sent and
// all parser state returns to its reset value.
// ---------------------------------------------------------------------------
module sexp_tokenizer_unit #(
   parameter int unsigned MAX_DEPTH = sexp_tok_pkg::MaxDepthDefault
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [sexp_tok_pkg::CharW-1:0] req_code_point,
   input  logic                           req_end_marker,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [3:0]                     rsp_event_res,
   output logic [sexp_tok_pkg::CharW-1:0] rsp_char_value,
   output logic [sexp_tok_pkg::NestW-1:0] rsp_nest_depth,
   output logic                           rsp_last_of_item
);

   // input register
   logic                           s1_valid_ff, s1_valid_in;
   logic [sexp_tok_pkg::CharW-1:0] s1_cp_ff;
   logic                           s1_end_ff;

   sexp_tok_pkg::pair_type pair;
   logic                   q_ready;
   logic                   step_en;
   logic                   req_beat;

   // Advance the held item when the buffer can take its results, or when it
   // has none to give.
   assign step_en     = s1_valid_ff && (q_ready || pair.count == 2'd0);
   assign req_stall   = s1_valid_ff && !step_en;
   assign req_beat    = req_valid && !req_stall;
   assign s1_valid_in = req_beat || (s1_valid_ff && !step_en);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      // hold payload while stalled, load on a new beat
      if (req_beat) begin
         s1_cp_ff  <= req_code_point;
         s1_end_ff <= req_end_marker;
      end
   end

   sexp_tok_core #(
      .MAX_DEPTH (MAX_DEPTH)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .step_en    (step_en),
      .code_point (s1_cp_ff),
      .end_marker (s1_end_ff),
      .pair       (pair)
   );

   sexp_tok_outq u_outq (
      .clock            (clock),
      .reset            (reset),
      .load_en          (step_en && pair.count != 2'd0),
      .load_pair        (pair),
      .ready            (q_ready),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_event_res    (rsp_event_res),
      .rsp_char_value   (rsp_char_value),
      .rsp_nest_depth   (rsp_nest_depth),
      .rsp_last_of_item (rsp_last_of_item)
   );

endmodule

// File: test/tb_sexp_tokenizer_unit.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Testbench for sexp_tokenizer_unit
// Feeds directed and random S-expression text, one code point per beat, and
// checks every token event against a cycle-free predictor of the tokenizer.
// ---------------------------------------------------------------------------

// one expected or observed token event
typedef struct packed {
   sexp_tok_pkg::event_type        ev;
   logic [sexp_tok_pkg::CharW-1:0] ch;
   logic [sexp_tok_pkg::NestW-1:0] depth;
   logic                           tail;
} token_beat_type;

// one request beat: a code point or the end of the text
typedef struct packed {
   logic [sexp_tok_pkg::CharW-1:0] cp;
   logic                           fin;
} text_item_type;

class token_scoreboard;
   token_beat_type due_q[$];
   int unsigned    errors;
   bit             esc_open, atom_open, str_open, top_done, halted;
   int unsigned    nest;

   function new();
      errors = 0;
      clear_state();
   endfunction

   function void clear_state();
      esc_open  = 1'b0;
      atom_open = 1'b0;
      str_open  = 1'b0;
      top_done  = 1'b0;
      halted    = 1'b0;
      nest      = 0;
   endfunction

   function bit blank_char(logic [sexp_tok_pkg::CharW-1:0] c);
      return (c >= 21'h09 && c <= 21'h0D) || (c >= 21'h1C && c <= 21'h20) ||
             (c >= 21'h2000 && c <= 21'h200A) || c == 21'h85 || c == 21'hA0 ||
             c == 21'h1680 || c == 21'h2028 || c == 21'h2029 || c == 21'h202F ||
             c == 21'h205F || c == 21'h3000;
   endfunction

   function void decode_escape(input logic [sexp_tok_pkg::CharW-1:0] c, output bit known,
                               output logic [sexp_tok_pkg::CharW-1:0] t);
      known = 1'b1;
      t     = c;
      if (c == sexp_tok_pkg::CH_B) t = sexp_tok_pkg::CH_BS;
      else if (c == sexp_tok_pkg::CH_F) t = sexp_tok_pkg::CH_FF;
      else if (c == sexp_tok_pkg::CH_T) t = sexp_tok_pkg::CH_TAB;
      else if (c == sexp_tok_pkg::CH_N) t = sexp_tok_pkg::CH_LF;
      else if (c == sexp_tok_pkg::CH_R) t = sexp_tok_pkg::CH_CR;
      else if (c == sexp_tok_pkg::CH_V) t = sexp_tok_pkg::CH_VT;
      else if (c == sexp_tok_pkg::CH_A) t = sexp_tok_pkg::CH_BEL;
      else if (c != sexp_tok_pkg::CH_BSLASH && c != sexp_tok_pkg::CH_APOS &&
               c != sexp_tok_pkg::CH_QUOTE) known = 1'b0;
   endfunction

   function void push_token(sexp_tok_pkg::event_type ev, logic [sexp_tok_pkg::CharW-1:0] ch);
      token_beat_type b;
      b.ev    = ev;
      b.ch    = ch;
      b.depth = sexp_tok_pkg::NestW'(nest);
      b.tail  = 1'b0;
      due_q   = {due_q, b};
   endfunction

   function void mark_item();
      if (nest == 0) top_done = 1'b1;
   endfunction

   function void step_char(logic [sexp_tok_pkg::CharW-1:0] c);
      bit                             known;
      logic [sexp_tok_pkg::CharW-1:0] t;
      if (str_open) begin
         if (esc_open) begin
            esc_open = 1'b0;
            decode_escape(c, known, t);
            if (!known || c == sexp_tok_pkg::CH_QUOTE)
               push_token(sexp_tok_pkg::EV_SCHAR, sexp_tok_pkg::CH_BSLASH);
            push_token(sexp_tok_pkg::EV_SCHAR, t);
         end else if (c == sexp_tok_pkg::CH_BSLASH) begin
            esc_open = 1'b1;
         end else if (c == sexp_tok_pkg::CH_QUOTE) begin
            str_open = 1'b0;
            push_token(sexp_tok_pkg::EV_SEND, sexp_tok_pkg::CH_QUOTE);
            mark_item();
         end else begin
            push_token(sexp_tok_pkg::EV_SCHAR, c);
         end
         return;
      end
      if (atom_open) begin
         if (c == sexp_tok_pkg::CH_LPAR || c == sexp_tok_pkg::CH_RPAR ||
             c == sexp_tok_pkg::CH_QUOTE || blank_char(c)) begin
            atom_open = 1'b0;
            push_token(sexp_tok_pkg::EV_AEND, '0);
            mark_item();
         end else begin
            push_token(sexp_tok_pkg::EV_ACHAR, c);
            return;
         end
      end
      if (esc_open) begin
         esc_open = 1'b0;
         decode_escape(c, known, t);
         if (!known) push_token(sexp_tok_pkg::EV_ACHAR, sexp_tok_pkg::CH_BSLASH);
         atom_open = 1'b1;
         push_token(sexp_tok_pkg::EV_ACHAR, t);
      end else if (c == sexp_tok_pkg::CH_BSLASH) begin
         esc_open = 1'b1;
      end else if (blank_char(c)) begin
         // whitespace between tokens gives nothing
      end else if (c == sexp_tok_pkg::CH_LPAR) begin
         if (nest >= sexp_tok_pkg::MaxDepthDefault) begin
            halted = 1'b1;
            push_token(sexp_tok_pkg::EV_OVER, '0);
         end else begin
            nest++;
            push_token(sexp_tok_pkg::EV_OPEN, '0);
         end
      end else if (c == sexp_tok_pkg::CH_RPAR) begin
         if (nest == 0) begin
            halted = 1'b1;
            push_token(sexp_tok_pkg::EV_EXTRA, '0);
         end else begin
            nest--;
            push_token(sexp_tok_pkg::EV_CLOSE, '0);
            mark_item();
         end
      end else if (c == sexp_tok_pkg::CH_QUOTE) begin
         str_open = 1'b1;
         push_token(sexp_tok_pkg::EV_SCHAR, sexp_tok_pkg::CH_QUOTE);
      end else begin
         atom_open = 1'b1;
         push_token(sexp_tok_pkg::EV_ACHAR, c);
      end
   endfunction

   // note an accepted request beat and queue the events it causes
   function void note_item(logic [sexp_tok_pkg::CharW-1:0] cp, logic fin);
      int unsigned base;
      base = due_q.size();
      if (fin) begin
         if (atom_open && !halted) begin
            atom_open = 1'b0;
            push_token(sexp_tok_pkg::EV_AEND, '0);
            mark_item();
         end
         if (halted || nest != 0 || !top_done) push_token(sexp_tok_pkg::EV_BAD, '0);
         else push_token(sexp_tok_pkg::EV_OK, '0);
         clear_state();
      end else if (!halted) begin
         step_char(cp);
      end
      if (due_q.size() > base) due_q[due_q.size() - 1].tail = 1'b1;
   endfunction

   // compare an accepted response beat with the oldest expected event
   function void check_result(logic [3:0] ev, logic [sexp_tok_pkg::CharW-1:0] ch,
                              logic [sexp_tok_pkg::NestW-1:0] depth, logic tail);
      token_beat_type w;
      if (due_q.size() == 0) begin
         $error("unexpected response: event_res %0d char_value %0h nest_depth %0d",
                ev, ch, depth);
         errors++;
         return;
      end
      w = due_q.pop_front();
      if (ev !== w.ev) begin
         $error("event_res: expected %0d, got %0d", w.ev, ev);
         errors++;
      end
      if (ch !== w.ch) begin
         $error("char_value: expected %0h, got %0h", w.ch, ch);
         errors++;
      end
      if (depth !== w.depth) begin
         $error("nest_depth: expected %0d, got %0d", w.depth, depth);
         errors++;
      end
      if (tail !== w.tail) begin
         $error("last_of_item: expected %0b, got %0b", w.tail, tail);
         errors++;
      end
   endfunction
endclass

module tb_sexp_tokenizer_unit;

   localparam int unsigned HOLD_CYCLES = 200;   // long receiver hold-off
   localparam int unsigned PHASE_ITEMS = 60;    // request beats per random phase

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_stall;
   logic [sexp_tok_pkg::CharW-1:0] req_code_point = '0;
   logic                           req_end_marker = 1'b0;
   logic                           rsp_valid;
   logic                           rsp_stall = 1'b0;
   logic [3:0]                     rsp_event_res;
   logic [sexp_tok_pkg::CharW-1:0] rsp_char_value;
   logic [sexp_tok_pkg::NestW-1:0] rsp_nest_depth;
   logic                           rsp_last_of_item;

   token_scoreboard       sb;
   text_item_type         stim_q[$];
   int unsigned           items_sent = 0;
   int unsigned           send_idle_pct = 0;
   int unsigned           rsp_stall_pct = 0;
   // hold-off requests from the stimulus, served by the stall process
   int unsigned           hold_requests = 0;
   int unsigned           holds_served = 0;
   int unsigned           hold_left = 0;

   sexp_tokenizer_unit #(
      .MAX_DEPTH(sexp_tok_pkg::MaxDepthDefault)
   ) uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_code_point  (req_code_point),
      .req_end_marker  (req_end_marker),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_event_res   (rsp_event_res),
      .rsp_char_value  (rsp_char_value),
      .rsp_nest_depth  (rsp_nest_depth),
      .rsp_last_of_item(rsp_last_of_item)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Drive the response stall at each rising edge. A pending hold-off request
   // turns into a run of HOLD_CYCLES stalled cycles; otherwise stall at the
   // rate the current phase asks.
   initial begin
      forever begin
         @(posedge clock);
         if (hold_left == 0 && holds_served != hold_requests) begin
            holds_served++;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < rsp_stall_pct);
         end
      end
   end

   // Sample the response side at the falling edge: nothing moves between here
   // and the next rising edge, so a beat seen now is the beat taken there.
   always @(negedge clock) begin
      if (reset === 1'b0 && rsp_valid === 1'b1 && rsp_stall === 1'b0)
         sb.check_result(rsp_event_res, rsp_char_value, rsp_nest_depth, rsp_last_of_item);
   end

   // ---- text generation --------------------------------------------------

   function automatic void put_char(logic [sexp_tok_pkg::CharW-1:0] c);
      text_item_type t;
      t.cp   = c;
      t.fin  = 1'b0;
      stim_q = {stim_q, t};
   endfunction

   // the code point of an end beat is don't-care, so randomize it
   function automatic void put_end();
      text_item_type t;
      t.cp   = sexp_tok_pkg::CharW'($urandom);
      t.fin  = 1'b1;
      stim_q = {stim_q, t};
   endfunction

   // a character that starts or continues an atom on its own
   function automatic logic [sexp_tok_pkg::CharW-1:0] plain_char();
      logic [sexp_tok_pkg::CharW-1:0] c;
      case ($urandom_range(0, 4))
         0, 1, 2: c = sexp_tok_pkg::CharW'($urandom_range(21'h21, 21'h7E));
         3:       c = sexp_tok_pkg::CharW'($urandom_range(21'h80, 21'hFFFF));
         default: c = sexp_tok_pkg::CharW'($urandom);   // reaches past 0x10FFFF too
      endcase
      if (sb.blank_char(c) || c == sexp_tok_pkg::CH_LPAR || c == sexp_tok_pkg::CH_RPAR ||
          c == sexp_tok_pkg::CH_QUOTE || c == sexp_tok_pkg::CH_BSLASH)
         c = sexp_tok_pkg::CH_A;
      return c;
   endfunction

   function automatic logic [sexp_tok_pkg::CharW-1:0] ws_char();
      case ($urandom_range(0, 9))
         0:       return sexp_tok_pkg::CharW'($urandom_range(21'h09, 21'h0D));
         1:       return sexp_tok_pkg::CharW'($urandom_range(21'h1C, 21'h1F));
         2, 3, 4: return 21'h20;
         5:       return sexp_tok_pkg::CharW'($urandom_range(21'h2000, 21'h200A));
         6:       return 21'h85;
         7:       return 21'hA0;
         8:       return 21'h1680;
         default: begin
            case ($urandom_range(0, 4))
               0:       return 21'h2028;
               1:       return 21'h2029;
               2:       return 21'h202F;
               3:       return 21'h205F;
               default: return 21'h3000;
            endcase
         end
      endcase
   endfunction

   // the character after a backslash: known escapes, delimiters, anything
   function automatic logic [sexp_tok_pkg::CharW-1:0] esc_target();
      case ($urandom_range(0, 13))
         0:       return sexp_tok_pkg::CH_BSLASH;
         1:       return sexp_tok_pkg::CH_APOS;
         2:       return sexp_tok_pkg::CH_QUOTE;
         3:       return sexp_tok_pkg::CH_B;
         4:       return sexp_tok_pkg::CH_F;
         5:       return sexp_tok_pkg::CH_T;
         6:       return sexp_tok_pkg::CH_N;
         7:       return sexp_tok_pkg::CH_R;
         8:       return sexp_tok_pkg::CH_V;
         9:       return sexp_tok_pkg::CH_A;
         10:      return ($urandom_range(0, 1) != 0) ? sexp_tok_pkg::CH_LPAR
                                                     : sexp_tok_pkg::CH_RPAR;
         11:      return ws_char();
         12:      return plain_char();
         default: return sexp_tok_pkg::CharW'($urandom);
      endcase
   endfunction

   function automatic logic [sexp_tok_pkg::CharW-1:0] str_char();
      logic [sexp_tok_pkg::CharW-1:0] c;
      c = ($urandom_range(0, 3) != 0) ? sexp_tok_pkg::CharW'($urandom_range(21'h20, 21'h7E))
                                      : sexp_tok_pkg::CharW'($urandom);
      if (c == sexp_tok_pkg::CH_QUOTE || c == sexp_tok_pkg::CH_BSLASH) c = sexp_tok_pkg::CH_A;
      return c;
   endfunction

   function automatic void gen_gap();
      repeat ($urandom_range(1, 2)) put_char(ws_char());
   endfunction

   function automatic void gen_atom();
      if ($urandom_range(0, 5) == 0) begin
         put_char(sexp_tok_pkg::CH_BSLASH);
         put_char(esc_target());
      end else begin
         put_char(plain_char());
      end
      // a backslash inside an atom is an ordinary character
      repeat ($urandom_range(0, 6))
         put_char(($urandom_range(0, 7) == 0) ? sexp_tok_pkg::CH_BSLASH : plain_char());
   endfunction

   function automatic void gen_string();
      put_char(sexp_tok_pkg::CH_QUOTE);
      repeat ($urandom_range(0, 6)) begin
         if ($urandom_range(0, 4) == 0) begin
            put_char(sexp_tok_pkg::CH_BSLASH);
            put_char(esc_target());
         end else begin
            put_char(str_char());
         end
      end
      put_char(sexp_tok_pkg::CH_QUOTE);
   endfunction

   function automatic void gen_expr(int unsigned lvl);
      int unsigned k;
      int unsigned n;
      k = $urandom_range(0, 9);
      if (lvl > 0 && k < 4) begin
         put_char(sexp_tok_pkg::CH_LPAR);
         n = $urandom_range(0, 4);
         for (int unsigned i = 0; i < n; i++) begin
            if (i > 0 || $urandom_range(0, 1) != 0) gen_gap();
            gen_expr(lvl - 1);
         end
         if ($urandom_range(0, 2) == 0) gen_gap();
         put_char(sexp_tok_pkg::CH_RPAR);
      end else if (k < 7) begin
         gen_atom();
      end else begin
         gen_string();
      end
   endfunction

   // Build one text: mostly well-formed documents with random content, the
   // rest raw noise and broken input of every error kind but overflow.
   function automatic void gen_text();
      int unsigned k;
      int unsigned n;
      k = $urandom_range(0, 99);
      if (k < 75) begin
         if ($urandom_range(0, 4) == 0) gen_gap();
         n = $urandom_range(1, 3);
         for (int unsigned i = 0; i < n; i++) begin
            if (i > 0) gen_gap();
            gen_expr(3);
         end
         if ($urandom_range(0, 3) == 0) gen_gap();
         put_end();
      end else begin
         case (k % 5)
            0: begin
               // raw noise over all 21 bits, stray end beats included
               repeat ($urandom_range(3, 10)) begin
                  if ($urandom_range(0, 9) == 0) put_end();
                  else put_char(sexp_tok_pkg::CharW'($urandom));
               end
               put_end();
            end
            1: begin
               // close one level too many, then text that must be ignored
               gen_expr(2);
               put_char(sexp_tok_pkg::CH_RPAR);
               put_char(sexp_tok_pkg::CH_RPAR);
               put_char(plain_char());
               put_end();
            end
            2: begin
               put_char(sexp_tok_pkg::CH_LPAR);
               gen_expr(2);
               put_end();
            end
            3: begin
               if ($urandom_range(0, 1) != 0) gen_gap();
               put_end();
            end
            default: begin
               // end inside a string or right after a bare backslash
               if ($urandom_range(0, 1) != 0) begin
                  put_char(sexp_tok_pkg::CH_QUOTE);
                  put_char(str_char());
               end
               put_char(sexp_tok_pkg::CH_BSLASH);
               put_end();
            end
         endcase
      end
   endfunction

   function automatic void fill_directed();
      // a list holding an atom: escaped quote opens it without a
      // backslash, the inner backslash is plain, ')' ends atom and list
      put_char(sexp_tok_pkg::CH_LPAR);
      put_char(sexp_tok_pkg::CH_BSLASH);
      put_char(sexp_tok_pkg::CH_QUOTE);
      put_char(sexp_tok_pkg::CH_BSLASH);
      put_char(sexp_tok_pkg::CH_B);
      put_char(sexp_tok_pkg::CH_RPAR);
      put_end();
      // string: escaped quote keeps its backslash, unknown escape 'q' too
      put_char(sexp_tok_pkg::CH_QUOTE);
      put_char(sexp_tok_pkg::CH_BSLASH);
      put_char(sexp_tok_pkg::CH_QUOTE);
      put_char(sexp_tok_pkg::CH_BSLASH);
      put_char(21'h71);
      put_char(sexp_tok_pkg::CH_QUOTE);
      put_end();
      // unknown escape outside a string, atom ended by an open
      put_char(sexp_tok_pkg::CH_BSLASH);
      put_char(21'h7A);
      put_char(sexp_tok_pkg::CH_LPAR);
      put_end();
      // extra close, then a character that must be dropped
      put_char(sexp_tok_pkg::CH_RPAR);
      put_char(21'h78);
      put_end();
      // code point extremes as atom characters, atom closed by the end beat
      put_char(21'h000000);
      put_char(21'h1FFFFF);
      put_end();
      // unterminated string with a pending escape
      put_char(sexp_tok_pkg::CH_QUOTE);
      put_char(sexp_tok_pkg::CH_BSLASH);
      put_end();
   endfunction

   // ---- drivers ------------------------------------------------------------

   // Offer one beat, optionally after idle cycles, and hold it until taken.
   // Stall is sampled at the falling edge, the beat counts at the next rise.
   task automatic send_item(text_item_type t);
      bit taken;
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < send_idle_pct);
      end
      req_valid      <= 1'b1;
      req_code_point <= t.cp;
      req_end_marker <= t.fin;
      do begin
         @(negedge clock);
         taken = (req_stall === 1'b0);
         @(posedge clock);
      end while (!taken);
      sb.note_item(t.cp, t.fin);
      items_sent++;
   endtask

   task automatic send_all();
      while (stim_q.size() != 0) send_item(stim_q.pop_front());
   endtask

   // drop valid and hold off until every expected event has come out
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (sb.due_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic run_phase(int unsigned sidle, int unsigned ridle, int unsigned n_items);
      int unsigned target;
      send_idle_pct = sidle;
      rsp_stall_pct = ridle;
      target        = items_sent + n_items;
      while (items_sent < target) begin
         gen_text();
         send_all();
      end
      wait_drained();
   endtask

   // ---- main sequence --------------------------------------------------------

   initial begin
      sb = new();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      fill_directed();
      send_all();
      wait_drained();

      // Hold the receiver for a long stretch while the sender streams one
      // long atom back to back: the result buffer fills and stalls input.
      hold_requests++;
      repeat (60) put_char(plain_char());
      put_end();
      send_all();
      wait_drained();

      // nest to the depth limit, then one open more overflows it
      repeat (sexp_tok_pkg::MaxDepthDefault + 1) put_char(sexp_tok_pkg::CH_LPAR);
      put_char(plain_char());
      put_end();
      send_all();
      wait_drained();

      run_phase(0, 0, PHASE_ITEMS);
      run_phase(82, 0, PHASE_ITEMS);
      run_phase(0, 82, PHASE_ITEMS);
      run_phase(38, 38, PHASE_ITEMS);
      run_phase(0, 0, PHASE_ITEMS / 2);

      // let any item still in flight surface before the verdict
      repeat (20) @(posedge clock);
      if (sb.errors == 0 && sb.due_q.size() == 0) begin
         $display("tb_sexp_tokenizer_unit passed");
      end else begin
         $display("tb_sexp_tokenizer_unit failed");
      end
      $finish;
   end

   // bound the run well past the slowest legal schedule
   initial begin
      #3000000;
      $display("tb_sexp_tokenizer_unit failed");
      $finish;
   end

endmodule

// File: files.f
design/sexp_tok_pkg.sv
design/sexp_tok_core.sv
design/sexp_tok_outq.sv
design/sexp_tokenizer_unit.sv
test/tb_sexp_tokenizer_unit.sv
